// File: design/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle block.
// No dependencies.
package qte_pkg;

    localparam int TERM_W  = 34;
    localparam int CORD_W  = 37;
    localparam int ROOT_W  = 31;
    localparam int REM_W   = 62;
    localparam int SQRT_N  = 31;
    localparam int TAB_LEN = 24;

    localparam logic signed [TERM_W-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [TERM_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [14:0] PITCH_MAX = 15'd12868;
    localparam logic [15:0] ANGLE_LIM = 16'd25736;

    localparam logic signed [TERM_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    typedef struct packed {
        logic signed [TERM_W-1:0] sr;
        logic signed [TERM_W-1:0] cr;
        logic signed [TERM_W-1:0] sy;
        logic signed [TERM_W-1:0] cy;
        logic signed [TERM_W-1:0] sp;
        logic                     clamp;
    } term_t;

endpackage

// File: design/qte_terms.sv
// Product, sum and pitch remainder stages (three register stages).
// Depends on qte_pkg.
module qte_terms
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [15:0]       quat_w,
    input  logic signed [15:0]       quat_x,
    input  logic signed [15:0]       quat_y,
    input  logic signed [15:0]       quat_z,
    output logic                     out_valid,
    output logic [qte_pkg::REM_W-1:0] rem,
    output qte_pkg::term_t           terms
);

    localparam int TW = qte_pkg::TERM_W;

    logic [2:0] valid_reg;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg, wz_reg, xy_reg, zz_reg;
    qte_pkg::term_t t2_reg, t3_reg, t2_next;
    logic [qte_pkg::REM_W-1:0] rem_reg, rem_next;
    logic signed [31:0] spn;
    logic signed [63:0] sq;

    always_comb
    begin
        t2_next.sr = (TW'(wx_reg) + TW'(yz_reg)) <<< 1;
        t2_next.cr = qte_pkg::ONE_Q30 - ((TW'(xx_reg) + TW'(yy_reg)) <<< 1);
        t2_next.sp = (TW'(wy_reg) - TW'(zx_reg)) <<< 1;
        t2_next.sy = (TW'(wz_reg) + TW'(xy_reg)) <<< 1;
        t2_next.cy = qte_pkg::ONE_Q30 - ((TW'(yy_reg) + TW'(zz_reg)) <<< 1);
        t2_next.clamp = (t2_next.sp >= qte_pkg::ONE_Q30) || (t2_next.sp <= -qte_pkg::ONE_Q30);
    end

    always_comb
    begin
        spn = t2_reg.clamp ? 32'sd0 : t2_reg.sp[31:0];
        sq = spn * spn;
        rem_next = (qte_pkg::REM_W'(1) << 60) - qte_pkg::REM_W'(sq[60:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        wx_reg <= quat_w * quat_x;
        yz_reg <= quat_y * quat_z;
        xx_reg <= quat_x * quat_x;
        yy_reg <= quat_y * quat_y;
        wy_reg <= quat_w * quat_y;
        zx_reg <= quat_z * quat_x;
        wz_reg <= quat_w * quat_z;
        xy_reg <= quat_x * quat_y;
        zz_reg <= quat_z * quat_z;
        t2_reg <= t2_next;
        t3_reg <= t2_reg;
        rem_reg <= rem_next;
    end

    assign out_valid = valid_reg[2];
    assign rem = rem_reg;
    assign terms = t3_reg;

endmodule

// File: design/qte_isqrt.sv
// Pipelined floor square root, one result bit per stage; carries the terms.
// Depends on qte_pkg.
module qte_isqrt
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [qte_pkg::REM_W-1:0] rem,
    input  qte_pkg::term_t            in_terms,
    output logic                      out_valid,
    output logic [qte_pkg::ROOT_W-1:0] root,
    output qte_pkg::term_t            out_terms
);

    localparam int N = qte_pkg::SQRT_N;
    localparam int RW = qte_pkg::REM_W;

    logic [RW-1:0] v_reg [0:N-1];
    logic [RW-1:0] r_reg [0:N-1];
    logic [RW-1:0] v_next [0:N-1];
    logic [RW-1:0] r_next [0:N-1];
    qte_pkg::term_t t_reg [0:N-1];
    logic [N-1:0] valid_reg;

    always_comb
    begin
        logic [RW-1:0] v;
        logic [RW-1:0] r;
        logic [RW-1:0] b;
        logic [RW-1:0] s;
        for (int k = 0; k < N; k++)
        begin
            v = (k == 0) ? rem : v_reg[(k == 0) ? 0 : k-1];
            r = (k == 0) ? '0 : r_reg[(k == 0) ? 0 : k-1];
            b = RW'(1) << (60 - 2*k);
            s = r + b;
            if (v >= s)
            begin
                v_next[k] = v - s;
                r_next[k] = (r >> 1) + b;
            end
            else
            begin
                v_next[k] = v;
                r_next[k] = r >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            v_reg[k] <= v_next[k];
            r_reg[k] <= r_next[k];
            t_reg[k] <= (k == 0) ? in_terms : t_reg[(k == 0) ? 0 : k-1];
        end
    end

    assign out_valid = valid_reg[N-1];
    assign root = r_reg[N-1][qte_pkg::ROOT_W-1:0];
    assign out_terms = t_reg[N-1];

endmodule

// File: design/qte_cordic.sv
// Pipelined vectoring CORDIC atan2: one pre-rotation stage, then one stage per step.
// Depends on qte_pkg.
module qte_cordic
#(
    parameter int STEPS = 16
)
(
    input  logic                             clk,
    input  logic signed [qte_pkg::TERM_W-1:0] y_in,
    input  logic signed [qte_pkg::TERM_W-1:0] x_in,
    output logic signed [qte_pkg::TERM_W-1:0] angle
);

    localparam int CW = qte_pkg::CORD_W;
    localparam int TW = qte_pkg::TERM_W;

    logic signed [CW-1:0] x_reg [0:STEPS];
    logic signed [CW-1:0] y_reg [0:STEPS];
    logic signed [TW-1:0] z_reg [0:STEPS];
    logic [STEPS:0] zero_reg;
    logic signed [CW-1:0] x0_next, y0_next;
    logic signed [TW-1:0] z0_next;

    always_comb
    begin
        x0_next = CW'(x_in);
        y0_next = CW'(y_in);
        z0_next = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x0_next = CW'(y_in);
                y0_next = -CW'(x_in);
                z0_next = qte_pkg::HALF_PI_Q30;
            end
            else
            begin
                x0_next = -CW'(y_in);
                y0_next = CW'(x_in);
                z0_next = -qte_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= x0_next;
        y_reg[0] <= y0_next;
        z_reg[0] <= z0_next;
        zero_reg[0] <= (x_in == 0) && (y_in == 0);
        for (int i = 0; i < STEPS; i++)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (y_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + qte_pkg::ATAN_TAB[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - qte_pkg::ATAN_TAB[i];
            end
        end
    end

    assign angle = zero_reg[STEPS] ? '0 : z_reg[STEPS];

endmodule

// File: design/qte_round.sv
// Output stage: Q.30 to Q3.13 rounding, clamping and pitch saturation.
// Depends on qte_pkg.
module qte_round
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [qte_pkg::TERM_W-1:0] roll_z,
    input  logic signed [qte_pkg::TERM_W-1:0] pitch_z,
    input  logic signed [qte_pkg::TERM_W-1:0] yaw_z,
    input  logic                             clamp,
    input  logic                             clamp_neg,
    output logic                             done,
    output logic signed [15:0]               roll_angle,
    output logic signed [14:0]               pitch_angle,
    output logic signed [15:0]               yaw_angle,
    output logic                             pitch_clamped
);

    localparam int TW = qte_pkg::TERM_W;

    function automatic logic [17:0] rmag(input logic signed [TW-1:0] a);
        logic [TW-1:0] m;
        logic [TW:0] s;
        begin
            m = a[TW-1] ? TW'(-a) : TW'(a);
            s = {1'b0, m} + (TW+1)'(1 << 16);
            rmag = s[TW:17];
        end
    endfunction

    logic done_reg, clamped_reg;
    logic signed [15:0] roll_reg, yaw_reg, roll_next, yaw_next;
    logic signed [14:0] pitch_reg, pitch_next;
    logic [17:0] mr, mp, my;
    logic [15:0] lr, ly;
    logic [14:0] lp;

    always_comb
    begin
        mr = rmag(roll_z);
        mp = rmag(pitch_z);
        my = rmag(yaw_z);
        lr = (mr > 18'(qte_pkg::ANGLE_LIM)) ? qte_pkg::ANGLE_LIM : mr[15:0];
        ly = (my > 18'(qte_pkg::ANGLE_LIM)) ? qte_pkg::ANGLE_LIM : my[15:0];
        lp = (mp > 18'(qte_pkg::PITCH_MAX)) ? qte_pkg::PITCH_MAX : mp[14:0];
        roll_next = roll_z[TW-1] ? -$signed(lr) : $signed(lr);
        yaw_next = yaw_z[TW-1] ? -$signed(ly) : $signed(ly);
        if (clamp)
        begin
            pitch_next = clamp_neg ? -$signed(qte_pkg::PITCH_MAX) : $signed(qte_pkg::PITCH_MAX);
        end
        else
        begin
            pitch_next = pitch_z[TW-1] ? -$signed(lp) : $signed(lp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        roll_reg <= roll_next;
        pitch_reg <= pitch_next;
        yaw_reg <= yaw_next;
        clamped_reg <= clamp;
    end

    assign done = done_reg;
    assign roll_angle = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle = yaw_reg;
    assign pitch_clamped = clamped_reg;

endmodule

// File: design/quaternion_to_euler.sv
// Top level: quaternion (Q1.15) to ZYX Euler angles (Q3.13).
// Depends on qte_pkg, qte_terms, qte_isqrt, qte_cordic, qte_round.
//
// Usage:
//   Drive quat_w/x/y/z and pulse start; a transfer is taken at each rising
//   edge with start high and busy low. busy is always low: the datapath is a
//   fully pipelined chain that takes one quaternion every cycle.
//   Each result is shown for one cycle with done high, in input order.
//   The pipeline has 3 product/sum stages, 31 square root stages (one root
//   bit each), one CORDIC pre-rotation stage plus one stage per CORDIC step
//   (three lanes in parallel), and one rounding stage.
//   Throughput: one result per cycle.
//   Reset clears all valid bits; items in flight are dropped and nothing is
//   shown until new transfers arrive. The receiver cannot stall, so results
//   are never held back.
module quaternion_to_euler
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               done,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic               pitch_clamped
);

    localparam int TW = qte_pkg::TERM_W;
    localparam int CL = CORDIC_STEPS + 1;

    logic t_valid, s_valid;
    logic [qte_pkg::REM_W-1:0] rem;
    qte_pkg::term_t t_terms, s_terms;
    logic [qte_pkg::ROOT_W-1:0] root;
    logic signed [TW-1:0] roll_z, pitch_z, yaw_z;
    logic [CL-1:0] v_reg, c_reg, n_reg;

    assign busy = 1'b0;

    qte_terms u_terms
    (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .out_valid(t_valid), .rem(rem), .terms(t_terms)
    );

    qte_isqrt u_isqrt
    (
        .clk(clk), .rst_n(rst_n), .in_valid(t_valid), .rem(rem), .in_terms(t_terms),
        .out_valid(s_valid), .root(root), .out_terms(s_terms)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll
    (
        .clk(clk), .y_in(s_terms.sr), .x_in(s_terms.cr), .angle(roll_z)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch
    (
        .clk(clk), .y_in(s_terms.sp), .x_in(TW'(root)), .angle(pitch_z)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw
    (
        .clk(clk), .y_in(s_terms.sy), .x_in(s_terms.cy), .angle(yaw_z)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[CL-2:0], s_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= {c_reg[CL-2:0], s_terms.clamp};
        n_reg <= {n_reg[CL-2:0], s_terms.sp[TW-1]};
    end

    qte_round u_round
    (
        .clk(clk), .rst_n(rst_n), .in_valid(v_reg[CL-1]),
        .roll_z(roll_z), .pitch_z(pitch_z), .yaw_z(yaw_z),
        .clamp(c_reg[CL-1]), .clamp_neg(n_reg[CL-1]),
        .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
    );

endmodule

// File: design/qte_checker.sv
// Port-level checks for quaternion_to_euler, bound to the top level.
// Depends on quaternion_to_euler ports only.
module qte_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] roll_angle,
    input logic signed [14:0] pitch_angle,
    input logic signed [15:0] yaw_angle,
    input logic               pitch_clamped
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !done)
        else $error("done right after reset");

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pitch_clamped) |-> (pitch_angle == 15'sd12868 || pitch_angle == -15'sd12868))
        else $error("saturated pitch not at pi/2");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736
                  && yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736
                  && pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868))
        else $error("angle out of range");

endmodule

bind quaternion_to_euler qte_checker u_qte_checker
(
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .pitch_clamped(pitch_clamped)
);

// File: tb/tb_quaternion_to_euler.sv
// Testbench for quaternion_to_euler: directed table then random quaternions,
// each result checked against an in-bench CORDIC predictor or a table value.
// Depends on qte_pkg and the quaternion_to_euler RTL.
`timescale 1ns / 100ps

module tb_quaternion_to_euler;

    localparam int STEPS   = 16;
    localparam int LATENCY = 36 + STEPS;
    localparam int N_RAND  = 1850;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } euler_t;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        bit                 has_exp;
        euler_t             exp_angles;
    } quat_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic               busy, done;
    logic signed [15:0] roll_angle, yaw_angle;
    logic signed [14:0] pitch_angle;
    logic               pitch_clamped;

    euler_t pending_angles[$];
    int     errors = 0;
    int     idle_pct = 0;

    quaternion_to_euler #(.CORDIC_STEPS(STEPS)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
    );

    always #5 clk = ~clk;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint vector_angle(longint yi, longint xi);
        longint xv, yv, zv, t, dx, dy;
        int n;
        xv = xi;
        yv = yi;
        zv = 0;
        n = (STEPS > qte_pkg::TAB_LEN) ? qte_pkg::TAB_LEN : ((STEPS < 0) ? 0 : STEPS);
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            t = xv;
            if (yv >= 0)
            begin
                xv = yv; yv = -t; zv = qte_pkg::HALF_PI_Q30;
            end
            else
            begin
                xv = -yv; yv = t; zv = -longint'(qte_pkg::HALF_PI_Q30);
            end
        end
        for (int i = 0; i < n; i++)
        begin
            dx = shr_floor(yv, i);
            dy = shr_floor(xv, i);
            if (yv >= 0)
            begin
                xv += dx; yv -= dy; zv += qte_pkg::ATAN_TAB[i];
            end
            else
            begin
                xv -= dx; yv += dy; zv -= qte_pkg::ATAN_TAB[i];
            end
        end
        return zv;
    endfunction

    function automatic longint to_q13(longint a, longint lim);
        longint m;
        m = (a < 0) ? -a : a;
        m = (m + (64'sd1 <<< 16)) >>> 17;
        if (m > lim) m = lim;
        return (a < 0) ? -m : m;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv; res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic euler_t predict_angles(logic signed [15:0] qw, logic signed [15:0] qx,
                                              logic signed [15:0] qy, logic signed [15:0] qz);
        longint w, x, y, z, sr, cr, sp, sy, cy, one, c;
        euler_t r;
        w = qw; x = qx; y = qy; z = qz;
        one = 64'sd1 <<< 30;
        sr = 2 * (w * x + y * z);
        cr = one - 2 * (x * x + y * y);
        sp = 2 * (w * y - z * x);
        sy = 2 * (w * z + x * y);
        cy = one - 2 * (y * y + z * z);
        r.roll = 16'(to_q13(vector_angle(sr, cr), 25736));
        r.yaw  = 16'(to_q13(vector_angle(sy, cy), 25736));
        if (sp >= one || sp <= -one)
        begin
            r.pitch   = (sp < 0) ? -15'sd12868 : 15'sd12868;
            r.clamped = 1'b1;
        end
        else
        begin
            c = floor_sqrt((64'd1 << 60) - longint'(sp * sp));
            r.pitch   = 15'(to_q13(vector_angle(sp, c), 12868));
            r.clamped = 1'b0;
        end
        return r;
    endfunction

    task automatic send_quat(quat_row_t row);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        quat_w <= row.w; quat_x <= row.x; quat_y <= row.y; quat_z <= row.z;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (row.has_exp)
            pending_angles.push_back(row.exp_angles);
        else
            pending_angles.push_back(predict_angles(row.w, row.x, row.y, row.z));
    endtask

    always @(posedge clk)
    begin
        euler_t e;
        if (rst_n && done)
        begin
            if (pending_angles.size() == 0)
            begin
                $error("result with nothing pending");
                errors++;
            end
            else
            begin
                e = pending_angles.pop_front();
                if (roll_angle !== e.roll)
                begin
                    $error("roll_angle exp %0d got %0d", e.roll, roll_angle); errors++;
                end
                if (pitch_angle !== e.pitch)
                begin
                    $error("pitch_angle exp %0d got %0d", e.pitch, pitch_angle); errors++;
                end
                if (yaw_angle !== e.yaw)
                begin
                    $error("yaw_angle exp %0d got %0d", e.yaw, yaw_angle); errors++;
                end
                if (pitch_clamped !== e.clamped)
                begin
                    $error("pitch_clamped exp %0d got %0d", e.clamped, pitch_clamped);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 46341)) - 16'sd23170;
            2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'(int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    initial
    begin
        quat_row_t tbl[$];
        quat_row_t row;
        int k;
        // directed rows: identity, zero, extremes, pitch saturation both ways
        tbl.push_back('{16'sh7fff, 0, 0, 0, 1'b0, '0});
        tbl.push_back('{0, 0, 0, 0, 1'b1, '{16'sd0, 15'sd0, 16'sd0, 1'b0}});
        tbl.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0});
        tbl.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0});
        tbl.push_back('{16'sh7fff, 0, 16'sh7fff, 0, 1'b1,
                        '{16'sd25736, 15'sd12868, 16'sd25736, 1'b1}});
        tbl.push_back('{16'sh7fff, 0, 16'sh8000, 0, 1'b0, '0});
        tbl.push_back('{23170, 0, 23170, 0, 1'b0, '0});
        tbl.push_back('{23170, 0, -23170, 0, 1'b0, '0});
        tbl.push_back('{0, 16'sh7fff, 0, 0, 1'b0, '0});
        tbl.push_back('{0, 0, 0, 16'sh7fff, 1'b0, '0});
        tbl.push_back('{0, 0, 16'sh7fff, 0, 1'b0, '0});
        tbl.push_back('{0, 16'sh8000, 0, 0, 1'b0, '0});
        tbl.push_back('{1, 16'sh7fff, 0, 0, 1'b0, '0});
        tbl.push_back('{-1, 16'sh7fff, 0, 0, 1'b0, '0});
        tbl.push_back('{16'sh8000, 0, 0, 0, 1'b0, '0});
        tbl.push_back('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0, '0});
        tbl.push_back('{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 1'b0, '0});
        tbl.push_back('{16'sh7fff, 16'sh7fff, 0, 0, 1'b0, '0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (tbl[i])
            send_quat(tbl[i]);
        for (int n = 0; n < N_RAND; n++)
        begin
            case ((n * 4) / N_RAND)
                0: idle_pct = 0;
                1: idle_pct = 58;
                2: idle_pct = 14;
                default: idle_pct = ($urandom_range(1)) ? 0 : 58;
            endcase
            k = $urandom_range(3);
            row.w = rand_comp(k);
            row.x = rand_comp($urandom_range(1) ? k : $urandom_range(3));
            row.y = rand_comp(k);
            row.z = rand_comp($urandom_range(3));
            row.has_exp = 1'b0;
            row.exp_angles = '0;
            send_quat(row);
        end
        start <= 1'b0;
        while (pending_angles.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
design/qte_pkg.sv
design/qte_terms.sv
design/qte_isqrt.sv
design/qte_cordic.sv
design/qte_round.sv
design/quaternion_to_euler.sv
design/qte_checker.sv
tb/tb_quaternion_to_euler.sv
